// ===== rtl/srfp_pkg.sv =====
`default_nettype none

package srfp_pkg;

  // Default depth of the frame byte store.
  localparam int MAX_FRAME_BYTES_DEF = 16;

  // Width of a frame length.
  localparam int LEN_W = 5;

  // Frame header bytes.
  localparam logic [7:0] HDR_MEAS = 8'hAA;
  localparam logic [7:0] HDR_TEMP = 8'hAB;
  localparam logic [7:0] HDR_STAT = 8'hAC;

  // Frame lengths in bytes.
  localparam logic [LEN_W-1:0] LEN_NONE  = 5'd0;
  localparam logic [LEN_W-1:0] LEN_SHORT = 5'd6;
  localparam logic [LEN_W-1:0] LEN_MID   = 5'd14;
  localparam logic [LEN_W-1:0] LEN_LONG  = 5'd16;

  // Frame kinds reported on the result channel.
  localparam logic [2:0] KIND_MEAS = 3'd0;
  localparam logic [2:0] KIND_TEMP = 3'd1;
  localparam logic [2:0] KIND_STAT = 3'd2;
  localparam logic [2:0] KIND_CSUM = 3'd3;
  localparam logic [2:0] KIND_BADH = 3'd4;

  // Status codes decoded from a status frame.
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_CMD_ERR    = 3'd1;
  localparam logic [2:0] STAT_BUSY       = 3'd2;
  localparam logic [2:0] STAT_CAL_FAIL   = 3'd3;
  localparam logic [2:0] STAT_TEMP_RANGE = 3'd4;

  // Sensor model codes (layout families).
  localparam logic [2:0] MODEL_TRIPLE_0  = 3'd0;
  localparam logic [2:0] MODEL_TRIPLE_1  = 3'd1;
  localparam logic [2:0] MODEL_DUAL_2    = 3'd2;
  localparam logic [2:0] MODEL_DUAL_3    = 3'd3;
  localparam logic [2:0] MODEL_LONG16    = 3'd4;
  localparam logic [2:0] MODEL_MEAS_ONLY = 3'd5;
  localparam logic [2:0] MODEL_LONG14    = 3'd6;

  typedef struct packed {
    logic [2:0]  frame_kind;
    logic [15:0] value_a;
    logic [31:0] value_b;
    logic [15:0] value_c;
    logic [15:0] value_d;
    logic [15:0] value_e;
    logic [15:0] value_f;
    logic [2:0]  status_code;
  } result_t;

  // Frame length that a header byte opens under a sensor model; zero when
  // the byte is not a valid header for that model.
  function automatic logic [LEN_W-1:0] length_for(input logic [2:0] model,
                                                  input logic [7:0] hdr);
    logic [LEN_W-1:0] len;
    len = LEN_NONE;
    unique case (model)
      MODEL_TRIPLE_0, MODEL_TRIPLE_1: begin
        if (hdr == HDR_MEAS || hdr == HDR_TEMP || hdr == HDR_STAT) len = LEN_SHORT;
      end
      MODEL_DUAL_2, MODEL_DUAL_3: begin
        if (hdr == HDR_MEAS || hdr == HDR_STAT) len = LEN_SHORT;
      end
      MODEL_LONG16: begin
        if (hdr == HDR_MEAS) len = LEN_LONG;
        else if (hdr == HDR_STAT) len = LEN_SHORT;
      end
      MODEL_MEAS_ONLY: begin
        if (hdr == HDR_MEAS) len = LEN_SHORT;
      end
      MODEL_LONG14: begin
        if (hdr == HDR_MEAS) len = LEN_MID;
        else if (hdr == HDR_STAT) len = LEN_SHORT;
      end
      default: begin
        len = LEN_NONE;
      end
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sensor_reply_frame_parser.sv =====
// Sensor reply frame parser. Bytes received from a water-quality sensor's
// UART arrive one per input transaction; the first byte of a frame is a
// header that, together with the sensor_model register, sets the frame
// length (6, 14 or 16 bytes), and the last byte must equal the 8-bit sum of
// the bytes before it. Each finished frame yields one output transaction
// carrying its kind, up to six big-endian raw readings and a decoded status
// code; a checksum mismatch yields a checksum-error transaction and drops
// the frame, and a byte that cannot start a frame yields a bad-header
// transaction and is dropped. The block sustains one byte per clock cycle
// unless a result is due while the output register is still full: a byte
// waits in the input register and is then folded into the running sum,
// counter and byte store in a single pass, and a frame's result is loaded
// into the output register at that same edge, where it waits until the
// consumer takes it.
// The input register keeps taking bytes while a result waits in the output
// register; only when a new result is due and the output register is still
// full does in_ready drop. Write sensor_model only while no frame is in
// flight; a write abandons any partial frame.
`default_nettype none

module sensor_reply_frame_parser
  import srfp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sensor_model_we,
  input  wire logic [2:0]  sensor_model,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       frame_kind,
  output logic [15:0]      value_a,
  output logic [31:0]      value_b,
  output logic [15:0]      value_c,
  output logic [15:0]      value_d,
  output logic [15:0]      value_e,
  output logic [15:0]      value_f,
  output logic [2:0]       status_code
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;
  logic       has_res;
  logic       out_free;
  result_t    res;
  result_t    res_q;

  // A byte leaves the input register when it produces no result, or when
  // the output register can take the result it produces.
  assign advance = s1_valid && (!has_res || out_free);

  srfp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .in_ready (in_ready),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  srfp_framer #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (sensor_model_we),
    .cfg_model (sensor_model),
    .in_byte   (s1_byte),
    .advance   (advance),
    .has_res   (has_res),
    .res       (res)
  );

  srfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_res),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .res_q     (res_q)
  );

  assign frame_kind  = res_q.frame_kind;
  assign value_a     = res_q.value_a;
  assign value_b     = res_q.value_b;
  assign value_c     = res_q.value_c;
  assign value_d     = res_q.value_d;
  assign value_e     = res_q.value_e;
  assign value_f     = res_q.value_f;
  assign status_code = res_q.status_code;

endmodule

`default_nettype wire

// ===== rtl/srfp_in_reg.sv =====
`default_nettype none

// Input register: holds one received byte until the framer consumes it.
module srfp_in_reg
  import srfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] rx_byte,
  input  wire logic       advance,
  output logic            in_ready,
  output logic            s1_valid,
  output logic [7:0]      s1_byte
);

  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srfp_framer.sv =====
`default_nettype none

// Frame state: byte counter, expected length, running checksum and the byte
// store, plus the decode of a finished frame into one result.
module srfp_framer
  import srfp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_model,
  input  wire logic [7:0] in_byte,
  input  wire logic       advance,
  output logic            has_res,
  output result_t         res
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

  logic [2:0]       model;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [LEN_W-1:0] exp_len;
  logic [LEN_W-1:0] exp_len_next;
  logic [7:0]       sum;
  logic [7:0]       sum_next;
  logic [7:0]       store [MAX_FRAME_BYTES];
  logic             wr_en;
  logic [LEN_W-1:0] hdr_len;
  logic [CNT_W-1:0] hdr_len_ext;
  logic [CNT_W-1:0] exp_ext;
  logic [CNT_W-1:0] count_inc;
  result_t          dec;

  assign hdr_len     = length_for(model, in_byte);
  assign hdr_len_ext = CNT_W'(hdr_len);
  assign exp_ext     = CNT_W'(exp_len);
  assign count_inc   = count + CNT_W'(1);

  // Decode of the stored frame; the checksum byte itself is never needed.
  always_comb begin
    dec = '0;
    if (store[0] == HDR_STAT) begin
      dec.frame_kind = KIND_STAT;
      if (store[1] <= 8'(STAT_CAL_FAIL)) begin
        dec.status_code = store[1][2:0];
      end else if (model == MODEL_LONG16) begin
        dec.status_code = STAT_CAL_FAIL;
      end else begin
        dec.status_code = STAT_TEMP_RANGE;
      end
    end else begin
      dec.frame_kind = (store[0] == HDR_TEMP) ? KIND_TEMP : KIND_MEAS;
      dec.value_a    = {store[1], store[2]};
      if (exp_len == LEN_LONG) begin
        dec.value_b = {store[3], store[4], store[5], store[6]};
        dec.value_c = {store[7], store[8]};
        dec.value_d = {store[9], store[10]};
        dec.value_e = {store[11], store[12]};
        dec.value_f = {store[13], store[14]};
      end else if (exp_len == LEN_MID) begin
        dec.value_b = {16'h0000, store[3], store[4]};
        dec.value_c = {store[5], store[6]};
        dec.value_d = {store[7], store[8]};
        dec.value_e = {store[9], store[10]};
        dec.value_f = {store[11], store[12]};
      end else begin
        dec.value_b = {16'h0000, store[3], store[4]};
      end
    end
  end

  always_comb begin
    count_next   = count;
    exp_len_next = exp_len;
    sum_next     = sum;
    wr_en        = 1'b0;
    has_res      = 1'b0;
    res          = '0;
    if (count == '0) begin
      if (hdr_len == LEN_NONE || hdr_len_ext > MAX_CNT) begin
        has_res        = 1'b1;
        res.frame_kind = KIND_BADH;
      end else begin
        exp_len_next = hdr_len;
        sum_next     = in_byte;
        count_next   = CNT_W'(1);
        wr_en        = 1'b1;
      end
    end else if (count >= exp_ext || count >= MAX_CNT) begin
      // Inconsistent state: restart the search for a header.
      count_next   = '0;
      exp_len_next = LEN_NONE;
      sum_next     = '0;
    end else begin
      wr_en = 1'b1;
      if (count_inc < exp_ext) begin
        sum_next   = sum + in_byte;
        count_next = count_inc;
      end else begin
        has_res = 1'b1;
        if (in_byte != sum) begin
          res.frame_kind = KIND_CSUM;
        end else begin
          res = dec;
        end
        count_next   = '0;
        exp_len_next = LEN_NONE;
        sum_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      model   <= MODEL_TRIPLE_0;
      count   <= '0;
      exp_len <= LEN_NONE;
      sum     <= '0;
    end else if (cfg_we) begin
      model   <= cfg_model;
      count   <= '0;
      exp_len <= LEN_NONE;
      sum     <= '0;
    end else if (advance) begin
      count   <= count_next;
      exp_len <= exp_len_next;
      sum     <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      store[count[IDX_W-1:0]] <= in_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srfp_out_reg.sv =====
`default_nettype none

// Result register: holds one result until the consumer takes it.
module srfp_out_reg
  import srfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res_in,
  input  wire logic    out_ready,
  output logic         out_valid,
  output logic         free,
  output result_t      res_q
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srfp_checker.sv =====
`default_nettype none

// Port-level checks for the frame parser.
module srfp_checker
  import srfp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  frame_kind,
  input wire logic [15:0] value_a,
  input wire logic [31:0] value_b,
  input wire logic [15:0] value_c,
  input wire logic [15:0] value_d,
  input wire logic [15:0] value_e,
  input wire logic [15:0] value_f,
  input wire logic [2:0]  status_code
);

  logic values_zero;
  assign values_zero = (value_a == '0) && (value_b == '0) && (value_c == '0) &&
                       (value_d == '0) && (value_e == '0) && (value_f == '0);

  // A result that waits keeps its kind, value_a, value_b and status code.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_kind) &&
    $stable(value_a) && $stable(value_b) && $stable(status_code))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_kind <= KIND_BADH)
    else $error("frame kind out of range");

  a_status_only_in_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind != KIND_STAT |-> status_code == STAT_OK)
    else $error("status code set outside a status frame");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_kind == KIND_CSUM || frame_kind == KIND_BADH ||
                  frame_kind == KIND_STAT) |-> values_zero)
    else $error("values set in a frame that carries none");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind == KIND_STAT |-> status_code <= STAT_TEMP_RANGE)
    else $error("status code out of range");

endmodule

bind sensor_reply_frame_parser srfp_checker u_srfp_checker (.*);

`default_nettype wire
